FILE: src/alsm_pkg.sv
// alsm_pkg: shared codes and types of the access lock state machine
// event, action and mode codes, register indexes, state and config structs
// no dependencies
`default_nettype none

package alsm_pkg;

  localparam logic [3:0] OP_RESET      = 4'd0;
  localparam logic [3:0] OP_TICK       = 4'd1;
  localparam logic [3:0] OP_CONNECT    = 4'd2;
  localparam logic [3:0] OP_DISCONNECT = 4'd3;
  localparam logic [3:0] OP_TAG_OK     = 4'd4;
  localparam logic [3:0] OP_TAG_FAIL   = 4'd5;
  localparam logic [3:0] OP_NEAR       = 4'd6;
  localparam logic [3:0] OP_FAR        = 4'd7;
  localparam logic [3:0] OP_AUTH_OK    = 4'd8;
  localparam logic [3:0] OP_AUTH_FAIL  = 4'd9;
  localparam logic [3:0] OP_USER_LOCK  = 4'd10;

  localparam logic [2:0] MODE_IDLE      = 3'd0;
  localparam logic [2:0] MODE_CONNECTED = 3'd1;
  localparam logic [2:0] MODE_TAGGED    = 3'd2;
  localparam logic [2:0] MODE_NEAR      = 3'd3;
  localparam logic [2:0] MODE_AUTHED    = 3'd4;
  localparam logic [2:0] MODE_UNLOCKED  = 3'd5;
  localparam logic [2:0] MODE_LOCKED    = 3'd6;
  localparam logic [2:0] MODE_LOCKOUT   = 3'd7;

  localparam logic [2:0] ACT_NONE        = 3'd0;
  localparam logic [2:0] ACT_LED_AUTH    = 3'd1;
  localparam logic [2:0] ACT_LED_LOCKED  = 3'd2;
  localparam logic [2:0] ACT_LED_UNLOCK  = 3'd3;
  localparam logic [2:0] ACT_PULSE       = 3'd4;
  localparam logic [2:0] ACT_DRIVE_LOCK  = 3'd5;
  localparam logic [2:0] ACT_LOG_LOCKOUT = 3'd6;

  localparam logic [1:0] REG_MAX_FAILS  = 2'd0;
  localparam logic [1:0] REG_LOCK_LEN   = 2'd1;
  localparam logic [1:0] REG_PENALTY_MS = 2'd2;
  localparam logic [1:0] REG_TIMEOUT_MS = 2'd3;

  localparam logic [7:0]  MAX_FAILS_RST  = 8'd3;
  localparam logic [31:0] LOCK_LEN_RST   = 32'd30000;
  localparam logic [31:0] PENALTY_MS_RST = 32'd2000;
  localparam logic [31:0] TIMEOUT_MS_RST = 32'd10000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] entered;
    logic [31:0] pen_dl;
    logic [31:0] lock_dl;
    logic [7:0]  streak;
  } alsm_state_t;

  typedef struct packed {
    logic [7:0]  max_fails;
    logic [31:0] lock_len;
    logic [31:0] penalty_ms;
    logic [31:0] timeout_ms;
  } alsm_cfg_t;

endpackage

`default_nettype wire

FILE: src/alsm_core.sv
// alsm_core: next-state and action logic for one event
// purely combinational, one event against the current state and config
// depends on alsm_pkg
`default_nettype none

module alsm_core (
  input  wire logic [3:0]            op_i,
  input  wire logic [31:0]           now_i,
  input  wire alsm_pkg::alsm_state_t st_i,
  input  wire alsm_pkg::alsm_cfg_t   cfg_i,
  output alsm_pkg::alsm_state_t      st_o,
  output logic [2:0]                 act_o
);
  import alsm_pkg::*;

  logic [7:0]  streak_inc;
  logic        fail_lock;
  logic        pen_active;
  logic        is_lockout;
  logic        transient;
  logic        do_fail;
  logic [31:0] elapsed;

  always_comb begin
    streak_inc = (st_i.streak == 8'hFF) ? 8'hFF : st_i.streak + 8'd1;
    fail_lock  = streak_inc >= cfg_i.max_fails;
    pen_active = now_i < st_i.pen_dl;
    is_lockout = st_i.mode == MODE_LOCKOUT;
    transient  = (st_i.mode == MODE_CONNECTED) || (st_i.mode == MODE_TAGGED) ||
                 (st_i.mode == MODE_NEAR) || (st_i.mode == MODE_AUTHED);
    elapsed    = now_i - st_i.entered;
    do_fail    = 1'b0;
    st_o       = st_i;
    act_o      = ACT_NONE;

    unique case (op_i)
      OP_RESET: begin
        st_o.mode    = MODE_IDLE;
        st_o.entered = now_i;
      end
      OP_TICK: begin
        if (is_lockout) begin
          if (now_i >= st_i.lock_dl) begin
            st_o.streak  = 8'd0;
            st_o.mode    = MODE_IDLE;
            st_o.entered = now_i;
            act_o        = ACT_LED_LOCKED;
          end
        end else if (transient && (elapsed > cfg_i.timeout_ms)) begin
          st_o.mode    = MODE_IDLE;
          st_o.entered = now_i;
          act_o        = ACT_LED_LOCKED;
        end
      end
      OP_DISCONNECT, OP_USER_LOCK: begin
        if (!is_lockout) begin
          st_o.mode    = MODE_LOCKED;
          st_o.entered = now_i;
          act_o        = ACT_DRIVE_LOCK;
        end
      end
      OP_CONNECT, OP_TAG_OK, OP_TAG_FAIL, OP_NEAR, OP_FAR, OP_AUTH_OK,
      OP_AUTH_FAIL: begin
        if (!is_lockout && !pen_active) begin
          unique case (st_i.mode)
            MODE_IDLE, MODE_LOCKED: begin
              if (op_i == OP_CONNECT) begin
                st_o.mode    = MODE_CONNECTED;
                st_o.entered = now_i;
                act_o        = ACT_LED_AUTH;
              end
            end
            MODE_CONNECTED: begin
              if (op_i == OP_TAG_OK) begin
                st_o.mode    = MODE_TAGGED;
                st_o.entered = now_i;
                act_o        = ACT_LED_AUTH;
              end else if (op_i == OP_TAG_FAIL) begin
                do_fail = 1'b1;
              end
            end
            MODE_TAGGED: begin
              if (op_i == OP_NEAR) begin
                st_o.mode    = MODE_NEAR;
                st_o.entered = now_i;
                act_o        = ACT_LED_AUTH;
              end else if (op_i == OP_FAR) begin
                st_o.mode    = MODE_IDLE;
                st_o.entered = now_i;
                act_o        = ACT_LED_LOCKED;
              end
            end
            MODE_NEAR: begin
              if (op_i == OP_AUTH_OK) begin
                st_o.streak  = 8'd0;
                st_o.mode    = MODE_UNLOCKED;
                st_o.entered = now_i;
                act_o        = ACT_PULSE;
              end else if (op_i == OP_AUTH_FAIL) begin
                do_fail = 1'b1;
              end else if (op_i == OP_FAR) begin
                st_o.mode    = MODE_IDLE;
                st_o.entered = now_i;
                act_o        = ACT_LED_LOCKED;
              end
            end
            MODE_UNLOCKED: begin
              if (op_i == OP_FAR) begin
                st_o.mode    = MODE_LOCKED;
                st_o.entered = now_i;
                act_o        = ACT_DRIVE_LOCK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    // failure: lockout once the streak reaches the limit, else penalty window
    if (do_fail) begin
      st_o.streak  = streak_inc;
      st_o.entered = now_i;
      if (fail_lock) begin
        st_o.lock_dl = now_i + cfg_i.lock_len;
        st_o.mode    = MODE_LOCKOUT;
        act_o        = ACT_LOG_LOCKOUT;
      end else begin
        st_o.pen_dl = now_i + cfg_i.penalty_ms;
        st_o.mode   = MODE_IDLE;
        act_o       = ACT_LED_LOCKED;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/access_lock_state_machine.sv
// access_lock_state_machine: top level with input register, state, result register
// and the register port; depends on alsm_pkg and alsm_core
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o  op_i, now_ms_i
//   out      source     out_valid_o / out_stall_i action_o, mode_o
//   cfg      sink       psel/penable/pwrite      paddr, pwdata, prdata
//
// one event per cycle unless the output stalls; input register, then result register
// the state registers update at the edge that loads the result register
// reset clears state, config to defaults and both valid flags
// a stalled output holds its result; input is stalled only when both stages are full
`default_nettype none

module access_lock_state_machine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  op_i,
  input  wire logic [31:0] now_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       action_o,
  output logic [2:0]       mode_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import alsm_pkg::*;

  alsm_cfg_t   cfg_q;
  alsm_state_t st_q, st_d;
  logic        ins_valid_q;
  logic [3:0]  ins_op_q;
  logic [31:0] ins_now_q;
  logic        res_valid_q;
  logic [2:0]  res_act_q, res_act_d;
  logic [2:0]  res_mode_q;
  logic        advance;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign advance = ins_valid_q && !(res_valid_q && out_stall_i);

  assign in_stall_o  = ins_valid_q && !advance;
  assign out_valid_o = res_valid_q;
  assign action_o    = res_act_q;
  assign mode_o      = res_mode_q;

  always_comb begin
    unique case (paddr[3:2])
      REG_MAX_FAILS:  prdata = {24'd0, cfg_q.max_fails};
      REG_LOCK_LEN:   prdata = cfg_q.lock_len;
      REG_PENALTY_MS: prdata = cfg_q.penalty_ms;
      REG_TIMEOUT_MS: prdata = cfg_q.timeout_ms;
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_fails  <= MAX_FAILS_RST;
      cfg_q.lock_len   <= LOCK_LEN_RST;
      cfg_q.penalty_ms <= PENALTY_MS_RST;
      cfg_q.timeout_ms <= TIMEOUT_MS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MAX_FAILS:  cfg_q.max_fails  <= pwdata[7:0];
        REG_LOCK_LEN:   cfg_q.lock_len   <= pwdata;
        REG_PENALTY_MS: cfg_q.penalty_ms <= pwdata;
        REG_TIMEOUT_MS: cfg_q.timeout_ms <= pwdata;
        default: begin
        end
      endcase
    end
  end

  alsm_core u_core (
    .op_i  (ins_op_q),
    .now_i (ins_now_q),
    .st_i  (st_q),
    .cfg_i (cfg_q),
    .st_o  (st_d),
    .act_o (res_act_d)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ins_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      ins_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      ins_op_q  <= op_i;
      ins_now_q <= now_ms_i;
    end
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        st_q        <= st_d;
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_act_q  <= res_act_d;
      res_mode_q <= st_d.mode;
    end
  end

  a_mode_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mode_o == st_q.mode)
    else $error("result mode differs from state");

  a_lockout_logged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && action_o == ACT_LOG_LOCKOUT) |-> mode_o == MODE_LOCKOUT)
    else $error("lockout logged outside lockout mode");

  a_unlock_clears_streak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && action_o == ACT_PULSE) |-> (st_q.streak == 8'd0 &&
      mode_o == MODE_UNLOCKED))
    else $error("unlock without cleared streak");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && ins_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
